FILE: hdl/rmwq_pkg.sv
package rmwq_pkg;

   // Widths fixed by the port definition
   localparam int OP_BITS     = 2;
   localparam int CTX_FIELD   = 8;
   localparam int STATUS_BITS = 3;

   typedef enum logic [OP_BITS-1:0] {
      OP_TRYLOCK = 2'd0,
      OP_LOCK    = 2'd1,
      OP_UNLOCK  = 2'd2
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 3'd0,
      ST_BUSY      = 3'd1,
      ST_QUEUED    = 3'd2,
      ST_FULL      = 3'd3,
      ST_UNDERFLOW = 3'd4,
      ST_SATURATED = 3'd5
   } status_type;

   typedef struct packed {
      op_type                 operation;
      logic [CTX_FIELD-1:0]   requester;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic                   wake_valid;
      logic [CTX_FIELD-1:0]   wake_context;
      logic                   held;
   } rsp_type;

endpackage

FILE: hdl/recursive_mutex_wait_queue.sv
// A request passes through the input register and then the result register before its rsp beat.
// One request per cycle while rsp_stall does not hold the result; the owner, count and queue ends update in one pass.
// Wake-up context comes from a registered-read RAM holding the waiters.
// Reset (synchronous, active high): mutex free, count 0, queue empty, recursive mode off.
// Queue storage is not cleared; only pushed entries are ever popped.
module recursive_mutex_wait_queue
   import rmwq_pkg::*;
#(
   parameter int WAIT_DEPTH   = 16,
   parameter int CONTEXT_BITS = 8,
   parameter int COUNT_MAX    = 255
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [OP_BITS-1:0]     req_operation,
   input  logic [CTX_FIELD-1:0]   req_requester,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic                   rsp_wake_valid,
   output logic [CTX_FIELD-1:0]   rsp_wake_context,
   output logic                   rsp_held,
   // configuration
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_recursive_mode
);

   // Only the low context bits take part; the port is eight bits wide
   localparam int CtxW = (CONTEXT_BITS < CTX_FIELD) ? CONTEXT_BITS : CTX_FIELD;

   logic    in_vld_ff, in_vld_in;
   req_type req_ff;
   logic    out_vld_ff, out_vld_in;
   rsp_type rsp_ff, core_rsp;
   logic    mode_ff;
   logic    go, req_take;

   // Request in the input register moves on when the result register is free
   // or being emptied this cycle.
   assign go        = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !go;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (go) begin
         in_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (go) begin
         out_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         mode_ff    <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_recursive_mode;
         end
      end
      if (req_take) begin
         req_ff.operation <= op_type'(req_operation);
         req_ff.requester <= req_requester;
      end
      if (go) begin
         rsp_ff <= core_rsp;
      end
   end

   // Mutex state, decision logic and waiter queue
   rmwq_core #(
      .WAIT_DEPTH (WAIT_DEPTH),
      .CTX_W      (CtxW),
      .COUNT_MAX  (COUNT_MAX)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .go    (go),
      .mode  (mode_ff),
      .req   (req_ff),
      .rsp   (core_rsp)
   );

   assign rsp_valid        = out_vld_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_wake_valid   = rsp_ff.wake_valid;
   assign rsp_wake_context = rsp_ff.wake_context;
   assign rsp_held         = rsp_ff.held;

endmodule

FILE: hdl/rmwq_ram.sv
module rmwq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/rmwq_core.sv
module rmwq_core
   import rmwq_pkg::*;
#(
   parameter int WAIT_DEPTH = 16,
   parameter int CTX_W      = 8,
   parameter int COUNT_MAX  = 255
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    go,
   input  logic    mode,
   input  req_type req,
   output rsp_type rsp
);

   localparam int PtrW  = $clog2(WAIT_DEPTH);
   localparam int FillW = $clog2(WAIT_DEPTH + 1);
   localparam int CntW  = $clog2(COUNT_MAX + 1);

   logic [CTX_W-1:0] owner_ff, owner_in;
   logic             owner_vld_ff, owner_vld_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic [PtrW-1:0]  head_ff, head_in;
   logic [PtrW-1:0]  tail_ff, tail_in;
   logic [FillW-1:0] fill_ff, fill_in;
   logic             byp_hit_ff;
   logic [CTX_W-1:0] byp_data_ff;

   logic             push, pop, self_owned;
   logic [CTX_W-1:0] who, head_word, ram_rdata;

   function automatic logic [PtrW-1:0] next_slot(input logic [PtrW-1:0] p);
      return (p == PtrW'(WAIT_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign who        = req.requester[CTX_W-1:0];
   assign self_owned = mode && owner_vld_ff && (owner_ff == who);
   // RAM reads at the next head every cycle; a write to that slot is bypassed
   assign head_word  = byp_hit_ff ? byp_data_ff : ram_rdata;

   always_comb begin
      owner_in     = owner_ff;
      owner_vld_in = owner_vld_ff;
      count_in     = count_ff;
      push         = 1'b0;
      pop          = 1'b0;
      rsp.status       = ST_OK;
      rsp.wake_valid   = 1'b0;
      rsp.wake_context = '0;
      if (go) begin
         case (op_type'(req.operation))
            OP_TRYLOCK, OP_LOCK: begin
               if (self_owned) begin
                  if (count_ff >= CntW'(COUNT_MAX)) begin
                     rsp.status = ST_SATURATED;
                  end else begin
                     count_in = count_ff + 1'b1;
                  end
               end else if (count_ff != '0) begin
                  if (req.operation == OP_TRYLOCK) begin
                     rsp.status = ST_BUSY;
                  end else if (fill_ff == FillW'(WAIT_DEPTH)) begin
                     rsp.status = ST_FULL;
                  end else begin
                     push       = 1'b1;
                     rsp.status = ST_QUEUED;
                  end
               end else begin
                  owner_in     = who;
                  owner_vld_in = 1'b1;
                  count_in     = CntW'(1);
               end
            end
            OP_UNLOCK: begin
               if (count_ff == '0) begin
                  rsp.status = ST_UNDERFLOW;
               end else begin
                  count_in = count_ff - 1'b1;
                  if (count_ff == CntW'(1)) begin
                     owner_in     = '0;
                     owner_vld_in = 1'b0;
                     if (fill_ff != '0) begin
                        pop              = 1'b1;
                        rsp.wake_valid   = 1'b1;
                        rsp.wake_context = CTX_FIELD'(head_word);
                     end
                  end
               end
            end
            default: begin
               // unknown code: no change, held reported as is
            end
         endcase
      end
      rsp.held = (count_in != '0);
   end

   always_comb begin
      head_in = pop ? next_slot(head_ff) : head_ff;
      tail_in = push ? next_slot(tail_ff) : tail_ff;
      fill_in = fill_ff;
      if (push) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owner_ff     <= '0;
         owner_vld_ff <= 1'b0;
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         byp_hit_ff   <= 1'b0;
      end else begin
         owner_ff     <= owner_in;
         owner_vld_ff <= owner_vld_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         byp_hit_ff   <= push && (tail_ff == head_in);
      end
      byp_data_ff <= who;
   end

   rmwq_ram #(
      .WIDTH (CTX_W),
      .DEPTH (WAIT_DEPTH)
   ) u_wait_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (tail_ff),
      .wr_data (who),
      .rd_addr (head_in),
      .rd_data (ram_rdata)
   );

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FillW'(WAIT_DEPTH))
      else $error("wait queue fill beyond depth");

   a_owner_count: assert property (@(posedge clock) disable iff (reset)
      owner_vld_ff == (count_ff != '0))
      else $error("owner flag out of step with hold count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(COUNT_MAX))
      else $error("hold count beyond maximum");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty queue with apart pointers");

   a_push_fill: assert property (@(posedge clock) disable iff (reset)
      push |=> (fill_ff == $past(fill_ff) + 1'b1))
      else $error("push did not raise fill");

endmodule
